// File: rtl/vcc_pkg.sv
// Package for the vertex component converter: formats, stage types, byte-to-float tables.
package vcc_pkg;

    localparam logic [2:0] FMT_F32   = 3'd0;
    localparam logic [2:0] FMT_HALF  = 3'd1;
    localparam logic [2:0] FMT_SNORM = 3'd2;
    localparam logic [2:0] FMT_UNORM = 3'd3;

    localparam logic       MODE_DECODE = 1'b0;
    localparam logic       MODE_ENCODE = 1'b1;

    typedef logic [31:0] lut_t [256];

    // per-item control carried down the pipe
    typedef struct packed {
        logic [31:0] res;
        logic [2:0]  nbytes;
        logic        ok;
        logic        enc_byte;
        logic        neg;
        logic        nan;
        logic        zero;
        logic [7:0]  bexp;
    } ctl_t;

    // correctly rounded single of mag/127 (snorm) or mag/255 (unorm)
    function automatic logic [31:0] byte_to_float(logic [7:0] mag, logic neg, logic sgn);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] m;
        logic [63:0] low;
        logic [63:0] half;
        int          p;
        int          sh;
        logic [7:0]  ex;
        if (mag == 8'd0)
            return 32'd0;
        num = {56'd0, mag} << 40;
        if (sgn)
        begin
            q   = num / 127;
            rem = num % 127;
        end
        else
        begin
            q   = num / 255;
            rem = num % 255;
        end
        p = 0;
        for (int i = 0; i < 64; i++)
            if (q[i])
                p = i;
        sh   = p - 23;
        m    = q >> sh;
        low  = q & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (low > half || (low == half && (rem != 64'd0 || m[0])))
            m = m + 64'd1;
        if (m[24])
        begin
            m = m >> 1;
            p = p + 1;
        end
        ex = 8'(p - 40 + 127);
        return {neg, ex, m[22:0]};
    endfunction

    function automatic lut_t build_lut(logic sgn);
        lut_t       t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++)
        begin
            b = 8'(i);
            if (sgn && b[7])
                t[i] = byte_to_float(8'(9'd256 - {1'b0, b}), 1'b1, 1'b1);
            else
                t[i] = byte_to_float(b, 1'b0, sgn);
        end
        return t;
    endfunction

    localparam lut_t SNORM_LUT = build_lut(1'b1);
    localparam lut_t UNORM_LUT = build_lut(1'b0);

endpackage

// File: rtl/vertex_component_converter.sv
// Vertex component converter: four-stage pipeline between float32 and half/byte formats.
// An accepted word passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one word per cycle unless m_tready stalls; the four stages follow the
//   byte-encode path: multiply, round product, align and add one half, round and clamp.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
module vertex_component_converter
    import vcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] in_bits
    input  logic [3:0]  s_tuser,   // [0] mode, [3:1] format
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_bits, [34:32] out_bytes, [39:35] zero
    output logic        m_tuser    // [0] ok
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        adv1, adv2, adv3, adv4;
    ctl_t        c1_reg, c2_reg, c3_reg, c1_next;
    logic [31:0] p1_reg, p1_next;
    logic [32:0] pr2_reg, pr2_next;
    logic [49:0] s3_reg, s3_next;
    logic        st3_reg, st3_next, big3_reg, big3_next;
    logic [31:0] ob_reg, ob_next;
    logic [2:0]  nb_reg, nb_next;
    logic        ok_reg, ok_next;

    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // stage 1: decode, half pack, mantissa times scale
    logic        mode;
    logic [2:0]  fmt;
    logic [31:0] v;
    logic [31:0] hexp;
    logic [15:0] hpk;
    logic [3:0]  hpos;
    logic [9:0]  hman;
    logic [4:0]  hex;
    logic [9:0]  hnorm;
    logic [3:0]  hsh;
    logic [7:0]  bexp;
    logic [22:0] fman;
    logic [23:0] bigm;
    logic [3:0]  psh;
    logic [23:0] sub;
    logic [7:0]  kval;

    always_comb
    begin
        mode = s_tuser[0];
        fmt  = s_tuser[3:1];
        v    = s_tdata;

        hman  = v[9:0];
        hex   = v[14:10];
        hpos  = 4'd0;
        for (int i = 0; i < 10; i++)
            if (hman[i])
                hpos = 4'(i);
        hsh   = 4'd10 - hpos;
        hnorm = hman << hsh;
        if (hex == 5'h1F)
            hexp = {v[15], 8'hFF, hman, 13'd0};
        else if (hex != 5'd0)
            hexp = {v[15], 8'({3'd0, hex} + 8'd112), hman, 13'd0};
        else if (hman != 10'd0)
            hexp = {v[15], 8'(8'd113 - {4'd0, hsh}), hnorm, 13'd0};
        else
            hexp = {v[15], 31'd0};

        bexp = v[30:23];
        fman = v[22:0];
        bigm = {1'b1, fman};
        psh  = 4'(8'd113 - bexp);
        sub  = bigm >> psh;
        if (bexp >= 8'd143)
        begin
            if (bexp != 8'hFF || fman == 23'd0)
                hpk = {v[31], 15'h7C00};
            else if (fman[22:13] != 10'd0)
                hpk = {v[31], 5'h1F, fman[22:13]};
            else
                hpk = {v[31], 15'h7E00};
        end
        else if (bexp > 8'd112)
            hpk = {v[31], 5'(bexp - 8'd112), fman[22:13]};
        else if (bexp < 8'd102)
            hpk = {v[31], 15'd0};
        else
            hpk = {v[31], 5'd0, sub[22:13]};

        kval    = (fmt == FMT_SNORM) ? 8'd127 : 8'd255;
        p1_next = {(bexp != 8'd0), fman} * kval;

        c1_next          = '0;
        c1_next.neg      = v[31];
        c1_next.nan      = (bexp == 8'hFF) && (fman != 23'd0);
        c1_next.zero     = (bexp == 8'd0);
        c1_next.bexp     = bexp;
        c1_next.ok       = 1'b1;
        if (mode == MODE_DECODE)
        begin
            c1_next.nbytes = 3'd4;
            case (fmt)
                FMT_F32:   c1_next.res = v;
                FMT_HALF:  c1_next.res = hexp;
                FMT_SNORM: c1_next.res = SNORM_LUT[v[7:0]];
                FMT_UNORM: c1_next.res = UNORM_LUT[v[7:0]];
                default:
                begin
                    c1_next.nbytes = 3'd0;
                    c1_next.ok     = 1'b0;
                end
            endcase
        end
        else
        begin
            case (fmt)
                FMT_F32:
                begin
                    c1_next.res    = v;
                    c1_next.nbytes = 3'd4;
                end
                FMT_HALF:
                begin
                    c1_next.res    = {16'd0, hpk};
                    c1_next.nbytes = 3'd2;
                end
                FMT_SNORM, FMT_UNORM:
                begin
                    c1_next.enc_byte = 1'b1;
                    c1_next.nbytes   = 3'd1;
                end
                default: c1_next.nbytes = 3'd0;
            endcase
        end
    end

    // stage 2: round product to 24 significant bits
    logic [4:0]  plead;
    logic [3:0]  pl;
    logic [31:0] pmask;
    logic        pup;

    always_comb
    begin
        plead = 5'd24;
        for (int i = 24; i < 32; i++)
            if (p1_reg[i])
                plead = 5'(i);
        pl       = 4'(plead - 5'd23);
        pmask    = (32'd1 << (pl - 4'd1)) - 32'd1;
        pup      = p1_reg[pl - 4'd1] && (((p1_reg & pmask) != 32'd0) || p1_reg[pl]);
        pr2_next = (({1'b0, p1_reg} >> pl) + 33'(pup)) << pl;
    end

    // stage 3: align to 40 fraction bits, add one half
    logic [59:0] wide;
    logic [59:0] pf;
    logic [5:0]  lamt;
    logic [6:0]  ramt;

    always_comb
    begin
        wide = {27'd0, pr2_reg};
        lamt = 6'(c2_reg.bexp - 8'd110);
        ramt = 7'(8'd110 - c2_reg.bexp);
        if (c2_reg.bexp >= 8'd110)
        begin
            pf       = wide << lamt;
            st3_next = 1'b0;
        end
        else
        begin
            pf       = wide >> ramt;
            st3_next = ((pf << ramt) != wide);
        end
        big3_next = (c2_reg.bexp >= 8'd137) || (pf[59:49] != 11'd0);
        s3_next   = {1'b0, pf[48:0]} + (50'd1 << 39);
    end

    // stage 4: round the sum, truncate, clamp
    logic [5:0]  slead;
    logic [4:0]  sl;
    logic [49:0] smask;
    logic        sup;
    logic [33:0] kept;
    logic [10:0] ival;
    logic [7:0]  bval;

    always_comb
    begin
        slead = 6'd39;
        for (int i = 39; i < 50; i++)
            if (s3_reg[i])
                slead = 6'(i);
        sl    = 5'(slead - 6'd23);
        smask = (50'd1 << (sl - 5'd1)) - 50'd1;
        sup   = s3_reg[sl - 5'd1]
                && (((s3_reg & smask) != 50'd0) || st3_reg || s3_reg[sl]);
        kept  = 34'(s3_reg >> sl) + 34'(sup);
        ival  = 11'(kept >> (6'd40 - {1'b0, sl}));
        if (c3_reg.nan || c3_reg.zero)
            bval = 8'd0;
        else if (big3_reg)
            bval = c3_reg.neg ? 8'h80 : 8'hFF;
        else if (c3_reg.neg)
            bval = (ival > 11'd128) ? 8'h80 : 8'(11'd0 - ival);
        else
            bval = (ival > 11'd255) ? 8'hFF : ival[7:0];
        ob_next = c3_reg.enc_byte ? {24'd0, bval} : c3_reg.res;
        nb_next = c3_reg.nbytes;
        ok_next = c3_reg.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            c1_reg <= c1_next;
            p1_reg <= p1_next;
        end
        if (adv2)
        begin
            c2_reg  <= c1_reg;
            pr2_reg <= pr2_next;
        end
        if (adv3)
        begin
            c3_reg   <= c2_reg;
            s3_reg   <= s3_next;
            st3_reg  <= st3_next;
            big3_reg <= big3_next;
        end
        if (adv4)
        begin
            ob_reg <= ob_next;
            nb_reg <= nb_next;
            ok_reg <= ok_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'd0, nb_reg, ob_reg};
    assign m_tuser  = ok_reg;

    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("pipeline stalls with empty output register");

    a_fail_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[34:0] == 35'd0)
        else $error("failed word carries data");

    a_byte_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] == 3'd1 |-> m_tdata[31:8] == 24'd0)
        else $error("byte word has high bits set");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && adv4 |=> v4_reg)
        else $error("word lost between stages");

endmodule

// File: bench/testbench.sv
// Self-checking stream testbench for the vertex component converter.
`timescale 1ns / 100ps

module testbench;
    import vcc_pkg::*;

    localparam logic [2:0] FMT_ABSENT = 3'd4;
    localparam logic [2:0] FMT_BAD    = 3'd7;

    typedef struct {
        logic        mode;
        logic [2:0]  fmt;
        logic [31:0] bits;
    } comp_t;

    typedef struct {
        logic [31:0] bits;
        logic [2:0]  nbytes;
        logic        ok;
    } conv_t;

    typedef struct {
        logic        mode;
        logic [2:0]  fmt;
        logic [31:0] bits;
        bit          typed;
        logic [31:0] ebits;
        logic [2:0]  ebytes;
        logic        eok;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    conv_t pending_q[$];
    bit    failed = 1'b0;
    bit    calm = 1'b0;

    always #5 clk = ~clk;

    vertex_component_converter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic logic [31:0] expand_half(logic [15:0] h);
        logic [31:0] r;
        logic [9:0]  man;
        logic [10:0] m;
        int          sh;
        r = {h[15], 31'd0};
        man = h[9:0];
        if (h[14:10] == 5'h1F)
            r[30:0] = {8'hFF, man, 13'd0};
        else if (h[14:10] != 5'd0)
            r[30:0] = {8'(h[14:10] + 8'd112), man, 13'd0};
        else if (man != 10'd0)
        begin
            m = {1'b0, man};
            sh = 0;
            while (!m[10])
            begin
                m = m << 1;
                sh++;
            end
            r[30:0] = {8'(113 - sh), m[9:0], 13'd0};
        end
        return r;
    endfunction

    function automatic logic [15:0] pack_half(logic [31:0] b);
        logic [15:0] sgn;
        int          ex;
        logic [22:0] man;
        logic [23:0] full;
        sgn = {b[31], 15'd0};
        ex = int'(b[30:23]) - 112;
        man = b[22:0];
        if (ex >= 31)
        begin
            if (b[30:23] != 8'hFF || man == 23'd0)
                return sgn | 16'h7C00;
            return sgn | 16'h7C00 | ((man[22:13] != 10'd0) ? {6'd0, man[22:13]} : 16'h0200);
        end
        if (ex > 0)
            return sgn | {1'b0, 5'(ex), man[22:13]};
        if (ex < -10)
            return sgn;
        full = {1'b1, man} >> (1 - ex);
        return sgn | {6'd0, full[22:13]};
    endfunction

    // correctly rounded single of mag/div, via long integer division
    function automatic logic [31:0] ratio_single(logic [7:0] mag, logic neg, int div);
        logic [63:0] num, q, rem, keep, drop, halfw;
        int          msb, sh;
        if (mag == 8'd0)
            return 32'd0;
        num = {56'd0, mag} << 40;
        q = num / div;
        rem = num % div;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (q[i])
                msb = i;
        sh = msb - 23;
        keep = q >> sh;
        drop = q - (keep << sh);
        halfw = 64'd1 << (sh - 1);
        if (drop > halfw || (drop == halfw && (rem != 0 || keep[0])))
            keep = keep + 1;
        if (keep[24])
        begin
            keep = keep >> 1;
            msb++;
        end
        return {neg, 8'(msb - 40 + 127), keep[22:0]};
    endfunction

    // round a double to the nearest single (normal range), ties to even
    function automatic real snap_single(real d);
        logic [63:0] x;
        logic [28:0] low;
        x = $realtobits(d);
        low = x[28:0];
        x[28:0] = '0;
        if (low > 29'h1000_0000 || (low == 29'h1000_0000 && x[29]))
            x = x + (64'd1 << 29);
        return $bitstoreal(x);
    endfunction

    function automatic logic [7:0] scale_to_byte(logic [31:0] b, int k);
        real f, p, r;
        int  w;
        if (b[30:23] == 8'hFF)
        begin
            if (b[22:0] != 23'd0)
                return 8'h00;
            return b[31] ? 8'h80 : 8'hFF;
        end
        // subnormal inputs scale to well under one half
        if (b[30:23] == 8'd0)
            return 8'h00;
        f = $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
        p = snap_single(f * k);
        r = snap_single(p < 0.0 ? p - 0.5 : p + 0.5);
        if (r <= -129.0)
            return 8'h80;
        if (r >= 256.0)
            return 8'hFF;
        w = $rtoi(r);
        if (w < -128)
            return 8'h80;
        if (w > 255)
            return 8'hFF;
        return 8'(w);
    endfunction

    function automatic conv_t convert_component(comp_t c);
        conv_t o;
        o.bits = '0;
        o.nbytes = 3'd0;
        o.ok = 1'b1;
        if (c.mode == MODE_DECODE)
        begin
            o.nbytes = 3'd4;
            case (c.fmt)
                FMT_F32:   o.bits = c.bits;
                FMT_HALF:  o.bits = expand_half(c.bits[15:0]);
                FMT_SNORM:
                    if (c.bits[7])
                        o.bits = ratio_single(8'(9'd256 - {1'b0, c.bits[7:0]}), 1'b1, 127);
                    else
                        o.bits = ratio_single(c.bits[7:0], 1'b0, 127);
                FMT_UNORM: o.bits = ratio_single(c.bits[7:0], 1'b0, 255);
                default:
                begin
                    o.nbytes = 3'd0;
                    o.ok = 1'b0;
                end
            endcase
        end
        else
        begin
            case (c.fmt)
                FMT_F32:
                begin
                    o.bits = c.bits;
                    o.nbytes = 3'd4;
                end
                FMT_HALF:
                begin
                    o.bits = {16'd0, pack_half(c.bits)};
                    o.nbytes = 3'd2;
                end
                FMT_SNORM:
                begin
                    o.bits = {24'd0, scale_to_byte(c.bits, 127)};
                    o.nbytes = 3'd1;
                end
                FMT_UNORM:
                begin
                    o.bits = {24'd0, scale_to_byte(c.bits, 255)};
                    o.nbytes = 3'd1;
                end
                default: ;
            endcase
        end
        return o;
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: b[30:23] = 8'($urandom_range(118, 136));   // byte range
            2: b[30:23] = 8'($urandom_range(98, 145));    // half edges
            3: b[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            4: b[30:23] = 8'($urandom_range(125, 127));
            default: b[22:0] = 23'($urandom_range(0, 3)) << 21;
        endcase
        return b;
    endfunction

    task automatic send_word(comp_t c, conv_t e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c.bits;
        s_tuser <= {c.fmt, c.mode};
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.insert(pending_q.size(), e);
        @(negedge clk);
    endtask

    // receiver stalls
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            k = calm ? 0 : $urandom_range(0, 10);
            if (k > 0)
            begin
                m_tready <= 1'b0;
                repeat (k) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        conv_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected word: out_bits %h", m_tdata[31:0]);
                failed = 1'b1;
            end
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata[31:0] !== e.bits)
                begin
                    $error("out_bits: expected %h actual %h", e.bits, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[34:32] !== e.nbytes)
                begin
                    $error("out_bytes: expected %0d actual %0d", e.nbytes, m_tdata[34:32]);
                    failed = 1'b1;
                end
                if (m_tdata[39:35] !== 5'd0)
                begin
                    $error("pad: expected 0 actual %h", m_tdata[39:35]);
                    failed = 1'b1;
                end
                if (m_tuser !== e.ok)
                begin
                    $error("ok: expected %b actual %b", e.ok, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("vertex_component_converter verification failed");
        $finish;
    end

    initial
    begin
        row_t  rows[$];
        comp_t c;
        conv_t e;
        int    wait_cycles;

        rows = '{
            '{MODE_DECODE, FMT_F32,    32'hDEADBEEF, 1, 32'hDEADBEEF, 3'd4, 1'b1},
            '{MODE_DECODE, FMT_ABSENT, 32'hFFFFFFFF, 1, 32'h0,        3'd0, 1'b0},
            '{MODE_DECODE, FMT_BAD,    32'h12345678, 1, 32'h0,        3'd0, 1'b0},
            '{MODE_DECODE, 3'd5,       32'h0,        1, 32'h0,        3'd0, 1'b0},
            '{MODE_ENCODE, FMT_ABSENT, 32'h3F800000, 1, 32'h0,        3'd0, 1'b1},
            '{MODE_ENCODE, 3'd6,       32'hFFFFFFFF, 1, 32'h0,        3'd0, 1'b1},
            '{MODE_ENCODE, FMT_F32,    32'hFFFFFFFF, 1, 32'hFFFFFFFF, 3'd4, 1'b1},
            '{MODE_DECODE, FMT_HALF,   32'hFFFF3C00, 1, 32'h3F800000, 3'd4, 1'b1},
            '{MODE_DECODE, FMT_HALF,   32'h00000001, 0, 0, 0, 0},
            '{MODE_DECODE, FMT_HALF,   32'h000083FF, 0, 0, 0, 0},
            '{MODE_DECODE, FMT_HALF,   32'h00007E01, 0, 0, 0, 0},
            '{MODE_ENCODE, FMT_HALF,   32'h7F800000, 1, 32'h7C00,     3'd2, 1'b1},
            '{MODE_ENCODE, FMT_HALF,   32'h7F800001, 1, 32'h7E00,     3'd2, 1'b1},
            '{MODE_ENCODE, FMT_HALF,   32'hFFC02000, 0, 0, 0, 0},
            '{MODE_ENCODE, FMT_HALF,   32'h47800000, 0, 0, 0, 0},
            '{MODE_ENCODE, FMT_HALF,   32'hB3800000, 0, 0, 0, 0},
            '{MODE_ENCODE, FMT_HALF,   32'h32000000, 0, 0, 0, 0},
            '{MODE_ENCODE, FMT_SNORM,  32'h3F800000, 1, 32'h7F,       3'd1, 1'b1},
            '{MODE_ENCODE, FMT_SNORM,  32'hBF800000, 1, 32'h81,       3'd1, 1'b1},
            '{MODE_ENCODE, FMT_UNORM,  32'h3F800000, 1, 32'hFF,       3'd1, 1'b1},
            '{MODE_ENCODE, FMT_UNORM,  32'h7FC00000, 1, 32'h0,        3'd1, 1'b1},
            '{MODE_ENCODE, FMT_UNORM,  32'hC0000000, 1, 32'h80,       3'd1, 1'b1},
            '{MODE_ENCODE, FMT_SNORM,  32'h40000000, 0, 0, 0, 0},
            '{MODE_DECODE, FMT_SNORM,  32'hFFFFFF80, 0, 0, 0, 0},
            '{MODE_DECODE, FMT_UNORM,  32'h0000017F, 0, 0, 0, 0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            c = '{rows[i].mode, rows[i].fmt, rows[i].bits};
            if (rows[i].typed)
                e = '{rows[i].ebits, rows[i].ebytes, rows[i].eok};
            else
                e = convert_component(c);
            send_word(c, e);
        end

        for (int n = 0; n < 930; n++)
        begin
            if (n % 120 == 0)
                calm = ($urandom_range(0, 3) == 0);
            c.mode = 1'($urandom_range(0, 1));
            c.fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3));
            c.bits = (c.mode == MODE_ENCODE || $urandom_range(0, 2) == 0) ? random_float()
                                                                          : $urandom;
            send_word(c, convert_component(c));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        wait_cycles = 0;
        while (pending_q.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (12) @(posedge clk);
        if (!failed && pending_q.size() == 0)
            $display("vertex_component_converter verification clean");
        else
        begin
            if (pending_q.size() != 0)
                $error("%0d expected words never arrived", pending_q.size());
            $display("vertex_component_converter verification failed");
        end
        $finish;
    end

endmodule
